@@ rtl/core/arp_cache_responder_defines.svh @@
// Assertion macros for the ARP cache responder.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ARP_CACHE_RESPONDER_DEFINES_SVH
`define ARP_CACHE_RESPONDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ARC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ARC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ARC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ARC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/arc_pkg.sv @@
package arc_pkg;

	localparam int CACHE_ENTRIES = 16;
	localparam int IDX_W         = $clog2(CACHE_ENTRIES);
	localparam int ENTRY_W       = 128;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 48;

	localparam logic        ACT_RECEIVE = 1'b0;
	localparam logic        ACT_LOOKUP  = 1'b1;
	localparam logic [10:0] MIN_ARP_LEN = 11'd28;
	localparam logic [15:0] HW_ETHERNET = 16'd1;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'd1;
	localparam logic [31:0] DEFAULT_LIFETIME_MS = 32'd60000;

	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_PRES  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME  = 8'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        action;
		logic [47:0] now_ms;
		logic [10:0] frame_length;
		logic [15:0] hw_type;
		logic [15:0] ptype;
		logic [15:0] opcode;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] tgt_ip;
		logic [31:0] query_ip;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic [47:0] found_mac;
		logic        reply_send;
		logic [47:0] reply_target_mac;
		logic [31:0] reply_target_ip;
		logic        request_send;
		logic        packet_dropped;
	} result_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [47:0] local_mac;
		logic        device_present;
		logic [31:0] entry_lifetime_ms;
	} cfg_t;

endpackage

@@ rtl/core/arc_if.sv @@
interface arc_item_if import arc_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface arc_result_if import arc_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface arc_cfg_if import arc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] value;
	modport source (output valid, output index, output value, input ready);
	modport sink   (input valid, input index, input value, output ready);
endinterface

@@ rtl/core/arc_ram.sv @@
module arc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/arc_cfg.sv @@
module arc_cfg import arc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	arc_cfg_if.sink   cfg,
	output cfg_t      regs
);
	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.local_ip          <= '0;
			regs_q.local_mac         <= '0;
			regs_q.device_present    <= 1'b0;
			regs_q.entry_lifetime_ms <= DEFAULT_LIFETIME_MS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LOCAL_IP:  regs_q.local_ip          <= cfg.value[31:0];
				CFG_LOCAL_MAC: regs_q.local_mac         <= cfg.value[47:0];
				CFG_DEV_PRES:  regs_q.device_present    <= cfg.value[0];
				CFG_LIFETIME:  regs_q.entry_lifetime_ms <= cfg.value[31:0];
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/core/arp_cache_responder.sv @@
// ARP cache responder.
// item channel: one transfer per action (receive a packet or look up an IP).
// result channel: exactly one transfer per item, in order.
// cfg channel: register writes, always ready; write only while idle.
// Cache lives in one RAM (ip, mac, stamp per entry, registered read); valid
// bits sit in flops so reset clears them at once and no clearing pass is run.
// Every action that reaches the cache scans all CACHE_ENTRIES slots, one RAM
// read per cycle; the states run in this order:
//   receive: scan, drain, write, done.
//   lookup: scan, drain, done.
//   dropped packet: straight to done, no RAM access.
// Input is ready again once the result is loaded into the output register; a
// stalled receiver keeps that result there, the next result waits in the done
// state and the input stays closed until the register frees.
// Reset: cache empty, lifetime 60000 ms, device absent, no result pending.
`include "arp_cache_responder_defines.svh"

module arp_cache_responder import arc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	arc_item_if.sink      item,
	arc_result_if.source  result,
	arc_cfg_if.sink       cfg
);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

	cfg_t    regs;
	state_t  state_q, state_d;
	item_t   item_q;

	logic [IDX_W-1:0]   cnt_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [ENTRY_W-1:0] rdata;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic               wr0_q;

	// scan results
	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [IDX_W-1:0] vic_idx_q;
	logic [47:0]      vic_stamp_q;
	logic             vic_done_q;
	logic             hit_q;
	logic [47:0]      mac_q;

	logic    res_vld_q;
	result_t res_q, res_d;

	logic             accept, out_free, ram_we, item_drop, q_drop;
	logic [IDX_W-1:0] wslot;
	logic [31:0]      e_ip;
	logic [47:0]      e_mac, e_stamp, stamp_eff, age;
	logic             e_vb;

	function automatic logic is_drop(item_t it);
		return (it.frame_length < MIN_ARP_LEN) || (it.hw_type != HW_ETHERNET) ||
		       (it.ptype != PROTO_IPV4);
	endfunction

	arc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign wslot = match_q ? match_idx_q : vic_idx_q;

	arc_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wslot),
		.wdata ({item_q.src_ip, item_q.src_mac, item_q.now_ms}),
		.raddr (cnt_q),
		.rdata (rdata)
	);

	assign item.ready   = (state_q == ST_IDLE);
	assign accept       = item.valid && item.ready;
	assign out_free     = !res_vld_q || result.ready;
	assign result.valid = res_vld_q;
	assign result.data  = res_q;
	assign item_drop    = is_drop(item.data);
	assign q_drop       = is_drop(item_q);

	// entry under evaluation; slot 0 keeps its raw stamp once written, even
	// after expiry, and reads as zero only before its first write
	assign e_vb      = valid_q[rd_idx_s1];
	assign e_ip      = rdata[127:96];
	assign e_mac     = rdata[95:48];
	assign e_stamp   = rdata[47:0];
	assign stamp_eff = (e_vb || wr0_q) ? e_stamp : 48'd0;
	assign age       = item_q.now_ms - e_stamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_d = (item.data.action == ACT_RECEIVE && item_drop) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = (item_q.action == ACT_RECEIVE) ? ST_WRITE : ST_DONE;
			end
			ST_WRITE: begin
				ram_we  = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result word from the latched item and scan flags
	always_comb begin
		res_d = '0;
		if (item_q.action == ACT_RECEIVE) begin
			if (q_drop) begin
				res_d.packet_dropped = 1'b1;
			end else if (regs.device_present && item_q.opcode == OP_REQUEST &&
			             item_q.tgt_ip == regs.local_ip) begin
				res_d.reply_send       = 1'b1;
				res_d.reply_target_mac = item_q.src_mac;
				res_d.reply_target_ip  = item_q.src_ip;
			end
		end else if (hit_q) begin
			res_d.hit       = 1'b1;
			res_d.found_mac = mac_q;
		end else begin
			res_d.request_send = regs.device_present;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item.data;
		end
		if (state_q == ST_DONE && out_free) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
	end

	// match, victim and expiry evaluation on the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			wr0_q   <= 1'b0;
			match_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (accept) begin
				match_q <= 1'b0;
				hit_q   <= 1'b0;
			end else if (rd_vld_s1 && !match_q && e_vb) begin
				if (item_q.action == ACT_RECEIVE) begin
					if (e_ip == item_q.src_ip) begin
						match_q <= 1'b1;
					end
				end else if (e_ip == item_q.query_ip) begin
					match_q <= 1'b1;
					if (age > {16'd0, regs.entry_lifetime_ms}) begin
						valid_q[rd_idx_s1] <= 1'b0;
					end else begin
						hit_q <= 1'b1;
					end
				end
			end
			if (ram_we) begin
				valid_q[wslot] <= 1'b1;
			end
			if (ram_we && wslot == '0) begin
				wr0_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (!match_q) begin
				match_idx_q <= rd_idx_s1;
				mac_q       <= e_mac;
			end
			if (rd_idx_s1 == '0) begin
				vic_idx_q   <= '0;
				vic_stamp_q <= stamp_eff;
				vic_done_q  <= 1'b0;
			end else if (!vic_done_q) begin
				if (!e_vb) begin
					vic_idx_q  <= rd_idx_s1;
					vic_done_q <= 1'b1;
				end else if (e_stamp < vic_stamp_q) begin
					vic_idx_q   <= rd_idx_s1;
					vic_stamp_q <= e_stamp;
				end
			end
		end
	end

	`ARC_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	`ARC_ASSERT_IMP(a_read_in_scan, clk, arst_n, rd_vld_s1,
		state_q == ST_SCAN || state_q == ST_DRAIN)
	`ARC_ASSERT_NXT(a_write_sets_valid, clk, arst_n, ram_we,
		$countones(valid_q) >= $past($countones(valid_q)) && valid_q != '0)

endmodule
